>>> src/qpd_pkg.sv
package qpd_pkg;

    // default sample width; the delta width is one bit less
    localparam int SAMPLE_WIDTH_DEF = 16;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIGNAL_DELTA = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOPE_DELTA  = 2'd1;

    // result beat: six flags packed from the lowest bit up
    localparam int OUT_DATA_W = 8;

    // per-channel status after one step
    typedef struct packed {
        logic valid;
        logic tracking;
        logic phase;
    } t_chan_flags;

endpackage

>>> src/qpd_channel.sv
module qpd_channel #(
    parameter int SAMPLE_WIDTH = qpd_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  logic signed [SAMPLE_WIDTH-1:0] i_value,
    input  logic        [SAMPLE_WIDTH-2:0] i_delta,
    input  logic                          i_permit_up,
    input  logic                          i_permit_down,
    output logic                          o_phase_cur,
    output qpd_pkg::t_chan_flags          o_flags
);

    logic                          r_phase;
    logic signed [SAMPLE_WIDTH-1:0] r_extreme;

    logic signed [SAMPLE_WIDTH:0] diff_dn;
    logic signed [SAMPLE_WIDTH:0] diff_up;
    logic signed [SAMPLE_WIDTH:0] delta_ext;
    logic                         beyond;
    logic                         new_extreme;
    logic                         flip;

    // differences one bit wider so they never wrap
    assign diff_dn   = {r_extreme[SAMPLE_WIDTH-1], r_extreme} - {i_value[SAMPLE_WIDTH-1], i_value};
    assign diff_up   = {i_value[SAMPLE_WIDTH-1], i_value} - {r_extreme[SAMPLE_WIDTH-1], r_extreme};
    assign delta_ext = $signed({2'b00, i_delta});

    always_comb begin
        if (r_phase) begin
            new_extreme = i_value < r_extreme;
            beyond      = diff_up > delta_ext;
            flip        = !new_extreme && beyond && i_permit_down;
        end else begin
            new_extreme = i_value > r_extreme;
            beyond      = diff_dn > delta_ext;
            flip        = !new_extreme && beyond && i_permit_up;
        end
    end

    assign o_phase_cur      = r_phase;
    assign o_flags.phase    = r_phase ^ flip;
    assign o_flags.tracking = new_extreme;
    assign o_flags.valid    = flip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= 1'b0;
            r_extreme <= '0;
        end else if (i_advance) begin
            r_phase <= r_phase ^ flip;
            if (new_extreme || flip) begin
                r_extreme <= i_value;
            end
        end
    end

endmodule

>>> src/quadrature_peak_delineator.sv
// Quadrature peak delineator. Each input beat carries a signed signal sample and its
// derivative; two coupled hysteresis trackers follow the running peak or trough of each
// and report phase, new-extreme (tracking) and phase-change (valid) flags, one result
// beat per input beat. A channel changes phase only once the value has retreated from
// its extreme by more than its delta and the other channel's phase agrees; the signal
// channel steps first and the slope channel sees its new phase. Throughput is one beat
// per clock while the result stream is not stalled; a beat passes from the input register
// to the result register, with the whole step (two subtract-and-compare pairs chained
// through the phase coupling) between them. The user must write deltas through the config
// port only while the block is idle; the block does not enforce it. Both reset to zero.
module quadrature_peak_delineator #(
    parameter int SAMPLE_WIDTH = qpd_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,

    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // sample [SAMPLE_WIDTH-1:0], slope [2*SAMPLE_WIDTH-1:SAMPLE_WIDTH], zero pad to bytes
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,

    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // sample_phase, sample_tracking, sample_valid, slope_phase, slope_tracking,
    // slope_valid from bit 0 up, bits 7:6 zero
    output logic [qpd_pkg::OUT_DATA_W-1:0] m_axis_tdata,

    // config write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [qpd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [SAMPLE_WIDTH-2:0]         i_cfg_data
);

    // delta registers
    logic [SAMPLE_WIDTH-2:0] r_signal_delta;
    logic [SAMPLE_WIDTH-2:0] r_slope_delta;

    // input register
    logic                          r_in_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_in_sample;
    logic signed [SAMPLE_WIDTH-1:0] r_in_slope;

    // result register
    logic                 r_out_valid;
    qpd_pkg::t_chan_flags r_out_sig;
    qpd_pkg::t_chan_flags r_out_slp;

    logic                 advance;
    logic                 sig_phase_cur;
    logic                 slp_phase_cur;
    qpd_pkg::t_chan_flags sig_flags;
    qpd_pkg::t_chan_flags slp_flags;

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signal_delta <= '0;
            r_slope_delta  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                qpd_pkg::CFG_SIGNAL_DELTA: r_signal_delta <= i_cfg_data;
                qpd_pkg::CFG_SLOPE_DELTA:  r_slope_delta  <= i_cfg_data;
                default: ; // unknown index is dropped
            endcase
        end
    end

    // item moves from the input register into the result register when the result slot
    // is free or being emptied this cycle
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // payload captured on every accepted beat, excess tdata bits ignored
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_sample <= s_axis_tdata[SAMPLE_WIDTH-1:0];
            r_in_slope  <= s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
        end
    end

    // signal channel steps first, gated by the slope phase before this step
    qpd_channel #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_sig (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_value       (r_in_sample),
        .i_delta       (r_signal_delta),
        .i_permit_up   (slp_phase_cur),
        .i_permit_down (!slp_phase_cur),
        .o_phase_cur   (sig_phase_cur),
        .o_flags       (sig_flags)
    );

    // slope channel is gated by the signal phase after its step
    qpd_channel #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_slp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_value       (r_in_slope),
        .i_delta       (r_slope_delta),
        .i_permit_up   (!sig_flags.phase),
        .i_permit_down (sig_flags.phase),
        .o_phase_cur   (slp_phase_cur),
        .o_flags       (slp_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_sig <= sig_flags;
            r_out_slp <= slp_flags;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00,
                            r_out_slp.valid, r_out_slp.tracking, r_out_slp.phase,
                            r_out_sig.valid, r_out_sig.tracking, r_out_sig.phase};

    // sig_phase_cur is not used: the slope side sees the post-step signal phase, as the
    // pre-step signal phase is not part of the coupling; it is sunk into unused_sig_phase
    logic unused_sig_phase;
    assign unused_sig_phase = sig_phase_cur;

endmodule

>>> src/qpd_checker.sv
module qpd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [qpd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    logic r_last_sig_phase;
    logic r_last_slp_phase;
    logic out_beat;

    assign out_beat = m_axis_tvalid && m_axis_tready;

    // phases of the last delivered result, both start at peak seeking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_sig_phase <= 1'b0;
            r_last_slp_phase <= 1'b0;
        end else if (out_beat) begin
            r_last_sig_phase <= m_axis_tdata[0];
            r_last_slp_phase <= m_axis_tdata[3];
        end
    end

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // signal phase moves between results exactly when the valid flag says so
    a_sig_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat |-> ((m_axis_tdata[0] != r_last_sig_phase) == m_axis_tdata[2]))
        else $error("signal phase change disagrees with valid flag");

    // same for the slope channel
    a_slp_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat |-> ((m_axis_tdata[3] != r_last_slp_phase) == m_axis_tdata[5]))
        else $error("slope phase change disagrees with valid flag");

    // a channel never tracks and changes phase on the same item
    a_trk_vld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat |-> !(m_axis_tdata[1] && m_axis_tdata[2]) && !(m_axis_tdata[4] && m_axis_tdata[5]))
        else $error("tracking and valid set together");

endmodule

bind quadrature_peak_delineator qpd_checker u_qpd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
